// ===== sv/rat_pkg.sv =====
// Shared types and constants for the rebinning average and threshold block.
`default_nettype none
package rat_pkg;

  localparam int OFFSET_W   = 16;
  localparam int BSIZE_W    = 8;
  localparam int MAXB_W     = 16;
  localparam int THR_W      = 15;
  localparam int IDX_W      = 16;
  localparam int CLASS_W    = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [OFFSET_W-1:0] START_OFFSET_RST = 16'd0;
  localparam logic [BSIZE_W-1:0]  BIN_SIZE_RST     = 8'd1;
  localparam logic [MAXB_W-1:0]   MAX_BINS_RST     = 16'd65535;
  localparam logic [THR_W-1:0]    THRESHOLD_RST    = 15'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_OFFSET = 2'd0,
    CFG_BIN_SIZE     = 2'd1,
    CFG_MAX_BINS     = 2'd2,
    CFG_THRESHOLD    = 2'd3
  } cfg_reg_t;

  typedef enum logic [CLASS_W-1:0] {
    LEVEL_WITHIN = 2'd0,
    LEVEL_ABOVE  = 2'd1,
    LEVEL_BELOW  = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_DIV,
    BE_OUT
  } back_state_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] start_offset;
    logic [BSIZE_W-1:0]  bin_size;
    logic [MAXB_W-1:0]   max_bins;
    logic [THR_W-1:0]    threshold;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/rat_in_if.sv =====
// Sample input channel: valid, ready and one sample with its record end flag.
`default_nettype none
interface rat_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           record_end;

  modport source (output valid, output sample, output record_end, input ready);
  modport sink   (input valid, input sample, input record_end, output ready);
endinterface
`default_nettype wire

// ===== sv/rat_out_if.sv =====
// Result output channel: valid, ready and one averaged bin with its class and index.
`default_nettype none
interface rat_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                               valid;
  logic                               ready;
  logic signed [SAMPLE_WIDTH-1:0]     bin_value;
  logic [rat_pkg::CLASS_W-1:0]        level_class;
  logic [rat_pkg::IDX_W-1:0]          bin_index;

  modport source (output valid, output bin_value, output level_class, output bin_index,
                  input ready);
  modport sink   (input valid, input bin_value, input level_class, input bin_index,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/rat_front.sv =====
// Front end: skips leading samples, accumulates bins and queues each finished bin sum.
`default_nettype none
module rat_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_BIN_SIZE = 255
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rat_pkg::cfg_t        cfg,
  rat_in_if.sink                    in_ch,
  output logic                      push,
  output logic [SAMPLE_WIDTH + 2 * $clog2(MAX_BIN_SIZE+1) + rat_pkg::IDX_W - 1:0] push_data,
  input  wire logic                 full
);

  localparam int FILL_W = $clog2(MAX_BIN_SIZE + 1);
  localparam int ACC_W  = SAMPLE_WIDTH + FILL_W;

  logic [rat_pkg::OFFSET_W-1:0] sample_position, sample_position_next;
  logic signed [ACC_W-1:0]      bin_accumulator, bin_accumulator_next;
  logic [FILL_W-1:0]            bin_fill, bin_fill_next;
  logic [rat_pkg::IDX_W-1:0]    bins_emitted, bins_emitted_next;
  logic                         record_done, record_done_next;

  logic                         fire;
  logic [rat_pkg::BSIZE_W-1:0]  bsz;
  logic [FILL_W-1:0]            n_eff;
  logic [rat_pkg::MAXB_W-1:0]   limit;
  logic signed [ACC_W-1:0]      acc_sum;
  logic [FILL_W-1:0]            fill_inc;
  logic [rat_pkg::IDX_W:0]      emitted_inc;

  assign in_ch.ready = !full;
  assign fire        = in_ch.valid && !full;

  always_comb begin
    bsz = (cfg.bin_size == '0) ? rat_pkg::BSIZE_W'(1) : cfg.bin_size;
    if (32'(bsz) > 32'(MAX_BIN_SIZE)) begin
      n_eff = FILL_W'(MAX_BIN_SIZE);
    end else begin
      n_eff = FILL_W'(bsz);
    end
    limit       = (cfg.max_bins == '0) ? rat_pkg::MAXB_W'(1) : cfg.max_bins;
    acc_sum     = bin_accumulator + ACC_W'(in_ch.sample);
    fill_inc    = bin_fill + FILL_W'(1);
    emitted_inc = {1'b0, bins_emitted} + (rat_pkg::IDX_W + 1)'(1);
    push_data   = {acc_sum, fill_inc, bins_emitted};

    sample_position_next = sample_position;
    bin_accumulator_next = bin_accumulator;
    bin_fill_next        = bin_fill;
    bins_emitted_next    = bins_emitted;
    record_done_next     = record_done;
    push                 = 1'b0;

    if (fire) begin
      if (!record_done) begin
        if (sample_position < cfg.start_offset) begin
          sample_position_next = sample_position + rat_pkg::OFFSET_W'(1);
        end else if (fill_inc >= n_eff) begin
          push                 = 1'b1;
          bins_emitted_next    = emitted_inc[rat_pkg::IDX_W-1:0];
          bin_accumulator_next = '0;
          bin_fill_next        = '0;
          if (emitted_inc >= {1'b0, limit}) begin
            record_done_next = 1'b1;
          end
        end else begin
          bin_accumulator_next = acc_sum;
          bin_fill_next        = fill_inc;
        end
      end
      // The last sample of a record is handled first, then everything starts over.
      if (in_ch.record_end) begin
        sample_position_next = '0;
        bin_accumulator_next = '0;
        bin_fill_next        = '0;
        bins_emitted_next    = '0;
        record_done_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      bin_accumulator <= '0;
      bin_fill        <= '0;
      bins_emitted    <= '0;
      record_done     <= 1'b0;
    end else begin
      sample_position <= sample_position_next;
      bin_accumulator <= bin_accumulator_next;
      bin_fill        <= bin_fill_next;
      bins_emitted    <= bins_emitted_next;
      record_done     <= record_done_next;
    end
  end

  a_done_no_partial: assert property (@(posedge clk) disable iff (rst)
    record_done |-> (bin_fill == '0 && bin_accumulator == '0))
    else $error("partial bin held after the bin limit was reached");

  a_push_clears_bin: assert property (@(posedge clk) disable iff (rst)
    push && !in_ch.record_end |=> (bin_fill == '0))
    else $error("bin not cleared after it was queued");

endmodule
`default_nettype wire

// ===== sv/rat_queue.sv =====
// Short queue of finished bin sums between the front end and the divider.
`default_nettype none
module rat_queue #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== sv/rat_back.sv =====
// Back end: rounded mean by bit-serial division, threshold class and output register.
`default_nettype none
module rat_back #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_BIN_SIZE = 255
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rat_pkg::cfg_t        cfg,
  output logic                      pop,
  input  wire logic [SAMPLE_WIDTH + 2 * $clog2(MAX_BIN_SIZE+1) + rat_pkg::IDX_W - 1:0] pop_data,
  input  wire logic                 empty,
  rat_out_if.source                 out_ch
);

  localparam int FILL_W = $clog2(MAX_BIN_SIZE + 1);
  localparam int ACC_W  = SAMPLE_WIDTH + FILL_W;
  localparam int NUM_W  = ACC_W + 2;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int CMP_W  = ((SAMPLE_WIDTH > rat_pkg::THR_W) ? SAMPLE_WIDTH : rat_pkg::THR_W) + 2;

  rat_pkg::back_state_t state, state_next;

  logic signed [ACC_W-1:0]        q_acc;
  logic [FILL_W-1:0]              q_fill;
  logic [rat_pkg::IDX_W-1:0]      q_idx;
  logic signed [NUM_W-1:0]        num;
  logic [NUM_W-1:0]               mag;

  logic [FILL_W:0]                div_rem, rem_next;
  logic [NUM_W-1:0]               div_q, q_next;
  logic [FILL_W:0]                div_den;
  logic                           div_neg;
  logic [CNT_W-1:0]               div_cnt;
  logic                           div_last;
  logic [FILL_W+1:0]              shifted;
  logic [SAMPLE_WIDTH-1:0]        mean_div;

  logic signed [SAMPLE_WIDTH-1:0] mean;
  logic [rat_pkg::IDX_W-1:0]      idx;
  logic                           out_load;
  logic signed [CMP_W-1:0]        mean_c, t_pos, t_neg;
  rat_pkg::level_t                cls;

  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_value;
  rat_pkg::level_t                out_class;
  logic [rat_pkg::IDX_W-1:0]      out_index;

  assign q_acc  = pop_data[ACC_W + FILL_W + rat_pkg::IDX_W - 1 -: ACC_W];
  assign q_fill = pop_data[FILL_W + rat_pkg::IDX_W - 1 -: FILL_W];
  assign q_idx  = pop_data[rat_pkg::IDX_W-1:0];

  // Mean is trunc((2S + n) / 2n) toward zero: divide the magnitude, then restore the sign.
  always_comb begin
    num = (NUM_W'(q_acc) <<< 1) + $signed(NUM_W'(q_fill));
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  always_comb begin
    shifted = {div_rem, div_q[NUM_W-1]};
    if (shifted >= {1'b0, div_den}) begin
      rem_next = (FILL_W+1)'(shifted - {1'b0, div_den});
      q_next   = {div_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_next = shifted[FILL_W:0];
      q_next   = {div_q[NUM_W-2:0], 1'b0};
    end
    mean_div = div_neg ? SAMPLE_WIDTH'(-q_next[SAMPLE_WIDTH-1:0])
                       : q_next[SAMPLE_WIDTH-1:0];
    div_last = (div_cnt == CNT_W'(NUM_W - 1));
  end

  always_comb begin
    mean_c = CMP_W'(mean);
    t_pos  = $signed({{(CMP_W - rat_pkg::THR_W){1'b0}}, cfg.threshold});
    t_neg  = -t_pos;
    if (mean_c > t_pos) begin
      cls = rat_pkg::LEVEL_ABOVE;
    end else if (mean_c < t_neg) begin
      cls = rat_pkg::LEVEL_BELOW;
    end else begin
      cls = rat_pkg::LEVEL_WITHIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rat_pkg::BE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    case (state)
      rat_pkg::BE_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          // A single-sample bin passes its sum through without rounding.
          state_next = (q_fill == FILL_W'(1)) ? rat_pkg::BE_OUT : rat_pkg::BE_DIV;
        end
      end
      rat_pkg::BE_DIV: begin
        if (div_last) begin
          state_next = rat_pkg::BE_OUT;
        end
      end
      rat_pkg::BE_OUT: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = rat_pkg::BE_IDLE;
        end
      end
      default: begin
        state_next = rat_pkg::BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == rat_pkg::BE_DIV) begin
      div_cnt <= div_last ? '0 : div_cnt + CNT_W'(1);
    end else begin
      div_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx     <= q_idx;
      mean    <= q_acc[SAMPLE_WIDTH-1:0];
      div_q   <= mag;
      div_rem <= '0;
      div_den <= {q_fill, 1'b0};
      div_neg <= num[NUM_W-1];
    end else if (state == rat_pkg::BE_DIV) begin
      div_rem <= rem_next;
      div_q   <= q_next;
      if (div_last) begin
        mean <= mean_div;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= mean;
      out_class <= cls;
      out_index <= idx;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.bin_value   = out_value;
  assign out_ch.level_class = out_class;
  assign out_ch.bin_index   = out_index;

  a_pop_starts_work: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != rat_pkg::BE_IDLE)
    else $error("transaction taken from the queue but no work started");

  a_div_two_or_more: assert property (@(posedge clk) disable iff (rst)
    state == rat_pkg::BE_DIV |-> div_den >= (FILL_W+1)'(4))
    else $error("divider running for a bin of fewer than two samples");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ch.ready))
    else $error("output register overwritten before its transaction completed");

endmodule
`default_nettype wire

// ===== sv/rebin_average_threshold_core.sv =====
// Top level of the rebinning average and threshold block: configuration and the three parts.
// The block skips the first start_offset samples of each record, averages groups of
// bin_size samples into one rounded mean and classifies it against +/-threshold. The
// front end takes one sample per cycle whenever the bin queue has room. Each bin of two
// or more samples then passes through the back end in order: it is taken from the queue,
// divided by one shift-subtract step per bit of the numerator 2S+n, and loaded into the
// output register; a single-sample bin skips the division. The back end takes no new bin
// until the last one is loaded into the output register, so for short bins the sustained
// rate is one bin per divider pass, with QUEUE_DEPTH bins absorbing bursts. Configuration
// is to be written only while idle; the block itself does not enforce it.
`default_nettype none
module rebin_average_threshold_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_BIN_SIZE = 255,
  parameter int QUEUE_DEPTH  = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  rat_in_if.sink                                 in_ch,
  rat_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [rat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rat_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FILL_W  = $clog2(MAX_BIN_SIZE + 1);
  localparam int ENTRY_W = SAMPLE_WIDTH + FILL_W + FILL_W + rat_pkg::IDX_W;

  rat_pkg::cfg_t      cfg;
  logic               push, pop, full, empty;
  logic [ENTRY_W-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_offset <= rat_pkg::START_OFFSET_RST;
      cfg.bin_size     <= rat_pkg::BIN_SIZE_RST;
      cfg.max_bins     <= rat_pkg::MAX_BINS_RST;
      cfg.threshold    <= rat_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      case (rat_pkg::cfg_reg_t'(cfg_index))
        rat_pkg::CFG_START_OFFSET: cfg.start_offset <= cfg_data[rat_pkg::OFFSET_W-1:0];
        rat_pkg::CFG_BIN_SIZE:     cfg.bin_size     <= cfg_data[rat_pkg::BSIZE_W-1:0];
        rat_pkg::CFG_MAX_BINS:     cfg.max_bins     <= cfg_data[rat_pkg::MAXB_W-1:0];
        rat_pkg::CFG_THRESHOLD:    cfg.threshold    <= cfg_data[rat_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rat_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_BIN_SIZE (MAX_BIN_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  rat_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  rat_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_BIN_SIZE (MAX_BIN_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ===== sim/tb_rebin_average_threshold_core.sv =====
// Self-checking testbench for rebin_average_threshold_core: directed and random records.
`default_nettype none
module tb_rebin_average_threshold_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W      = 16;
  localparam int MAX_BIN       = 255;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [SAMPLE_W-1:0]     value;
    rat_pkg::level_t                level;
    logic [rat_pkg::IDX_W-1:0]      index;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [rat_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rat_pkg::CFG_DATA_W-1:0] cfg_data;

  rat_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  rat_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_ch ();

  rebin_average_threshold_core #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .MAX_BIN_SIZE(MAX_BIN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the block's registers and record state.
  rat_pkg::cfg_t shadow_cfg = {rat_pkg::START_OFFSET_RST, rat_pkg::BIN_SIZE_RST,
                               rat_pkg::MAX_BINS_RST, rat_pkg::THRESHOLD_RST};
  int   skipped;
  int   group_sum;
  int   group_fill;
  int   bins_done;
  bit   bin_limit_hit;

  bin_result_t expected_bins[$];
  int          fail_count;
  bit          sender_idles;
  bit          receiver_idles;

  function automatic int effective_span();
    int span;
    span = (shadow_cfg.bin_size == 0) ? 1 : int'(shadow_cfg.bin_size);
    if (span > MAX_BIN) begin
      span = MAX_BIN;
    end
    return span;
  endfunction

  function automatic void clear_record();
    skipped       = 0;
    group_sum     = 0;
    group_fill    = 0;
    bins_done     = 0;
    bin_limit_hit = 1'b0;
  endfunction

  function automatic void predict_bin(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int          cap;
    int          mean;
    int          thr;
    bin_result_t r;
    if (!bin_limit_hit) begin
      if (skipped < int'(shadow_cfg.start_offset)) begin
        skipped++;
      end else begin
        cap = (shadow_cfg.max_bins == 0) ? 1 : int'(shadow_cfg.max_bins);
        group_sum += int'(s);
        group_fill++;
        if (group_fill >= effective_span()) begin
          // Rounded mean: (2*sum + n) / (2*n), quotient truncated toward zero.
          if (group_fill == 1) begin
            mean = group_sum;
          end else begin
            mean = (2 * group_sum + group_fill) / (2 * group_fill);
          end
          thr = int'(shadow_cfg.threshold);
          if (mean > thr) begin
            r.level = rat_pkg::LEVEL_ABOVE;
          end else if (mean < -thr) begin
            r.level = rat_pkg::LEVEL_BELOW;
          end else begin
            r.level = rat_pkg::LEVEL_WITHIN;
          end
          r.value = mean[SAMPLE_W-1:0];
          r.index = bins_done[rat_pkg::IDX_W-1:0];
          expected_bins.insert(expected_bins.size(), r);
          bins_done++;
          group_sum  = 0;
          group_fill = 0;
          if (bins_done >= cap) begin
            bin_limit_hit = 1'b1;
          end
        end
      end
    end
    if (last) begin
      clear_record();
    end
  endfunction

  // Leaves cfg_we high; the caller lowers it once the last write is done.
  task automatic put_reg(input rat_pkg::cfg_reg_t idx,
                         input logic [rat_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      rat_pkg::CFG_START_OFFSET: shadow_cfg.start_offset = data[rat_pkg::OFFSET_W-1:0];
      rat_pkg::CFG_BIN_SIZE:     shadow_cfg.bin_size     = data[rat_pkg::BSIZE_W-1:0];
      rat_pkg::CFG_MAX_BINS:     shadow_cfg.max_bins     = data[rat_pkg::MAXB_W-1:0];
      rat_pkg::CFG_THRESHOLD:    shadow_cfg.threshold    = data[rat_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [15:0] offset, input logic [15:0] bsize,
                                input logic [15:0] maxb, input logic [15:0] thr);
    put_reg(rat_pkg::CFG_START_OFFSET, offset);
    put_reg(rat_pkg::CFG_BIN_SIZE, bsize);
    put_reg(rat_pkg::CFG_MAX_BINS, maxb);
    put_reg(rat_pkg::CFG_THRESHOLD, thr);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.record_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_bin(s, last);
  endtask

  // Stop sending, let every expected bin arrive, then let the pipeline go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    int t;
    int v;
    t = int'(shadow_cfg.threshold);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($signed(16'($urandom())));
      4:          v = 32767;
      5:          v = -32768;
      6, 7, 8:    v = int'($urandom_range(0, 2 * t + 20)) - t - 10;
      default:    v = int'($urandom_range(0, 2)) - 1;
    endcase
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic test_reset_settings();
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
    settle();
  endtask

  // Skip, two-sample bins at full scale, the bin limit and a masked threshold.
  task automatic test_full_scale_pairs();
    write_settings(16'd2, 16'd2, 16'd3, 16'hFFFF);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd6, 1'b1);
    settle();
  endtask

  // Zero bin size and zero bin limit act as one; the largest offset skips everything.
  task automatic test_zero_sizes();
    write_settings(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd7, 1'b1);
    settle();
    write_settings(16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_sample(-16'sd4, 1'b0);
    send_sample(16'sd9, 1'b1);
    settle();
  endtask

  // Bin size and offset changed while a record is open.
  task automatic test_mid_record_changes();
    write_settings(16'd1, 16'd4, 16'hFFFF, 16'd100);
    send_sample(16'sd50, 1'b0);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd20, 1'b0);
    settle();
    write_settings(16'd1, 16'd2, 16'hFFFF, 16'd100);
    send_sample(16'sd30, 1'b0);
    settle();
    write_settings(16'd3, 16'd2, 16'hFFFF, 16'd100);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd40, 1'b0);
    send_sample(-16'sd41, 1'b0);
    send_sample(16'sd7, 1'b1);
    settle();
  endtask

  // Widest bins: the sum reaches its most negative and most positive values.
  task automatic test_full_scale_bins();
    write_settings(16'd0, 16'd255, 16'hFFFF, 16'($urandom()));
    repeat (MAX_BIN) send_sample(-16'sd32768, 1'b0);
    repeat (MAX_BIN) send_sample(16'sd32767, 1'b0);
    repeat (20) send_sample(draw_sample(), 1'b0);
    send_sample(draw_sample(), 1'b1);
    settle();
  endtask

  task automatic test_random_records(input int n_items, input bit quiet);
    logic [15:0] offset;
    logic [15:0] bsize;
    logic [15:0] maxb;
    logic [15:0] thr;
    int          sent;
    int          len;
    int          lead;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: offset = 16'($urandom_range(0, 4));
      6, 7:             offset = 16'($urandom_range(5, 40));
      8:                offset = 16'd0;
      default:          offset = 16'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: bsize = 16'($urandom_range(0, 8));
      7, 8:                bsize = 16'($urandom_range(9, 40));
      default:             bsize = 16'($urandom()) | 16'hFF00;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: maxb = 16'($urandom_range(0, 6));
      5, 6, 7:       maxb = 16'hFFFF;
      8:             maxb = 16'($urandom());
      default:       maxb = 16'd1;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: thr = 16'($urandom_range(0, 300));
      6:                thr = 16'd0;
      7:                thr = 16'h7FFF;
      default:          thr = 16'($urandom());
    endcase
    write_settings(offset, bsize, maxb, thr);
    sent = 0;
    while (sent < n_items) begin
      lead = (shadow_cfg.start_offset > 40) ? 0 : int'(shadow_cfg.start_offset);
      if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 12);
      end else begin
        len = lead + effective_span() * $urandom_range(1, 6) +
              $urandom_range(0, effective_span());
      end
      sender_idles   = !quiet && $urandom_range(0, 3) != 0;
      receiver_idles = !quiet && $urandom_range(0, 3) != 0;
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_sample(draw_sample(), k == len - 1);
        sent++;
      end
    end
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    settle();
  endtask

  // Result sink: random stall bursts while enabled.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_bins.size() == 0) begin
        $error("unexpected bin: bin_value %0d bin_index %0d", out_ch.bin_value,
               out_ch.bin_index);
        fail_count++;
      end else begin
        want = expected_bins.pop_front();
        if (out_ch.bin_value !== want.value) begin
          $error("bin_value: expected %0d, actual %0d", want.value, out_ch.bin_value);
          fail_count++;
        end
        if (out_ch.level_class !== want.level) begin
          $error("level_class: expected %0d, actual %0d", want.level, out_ch.level_class);
          fail_count++;
        end
        if (out_ch.bin_index !== want.index) begin
          $error("bin_index: expected %0d, actual %0d", want.index, out_ch.bin_index);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("** rebin_average_threshold_core: FAILED **");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = rat_pkg::CFG_START_OFFSET;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.record_end = 1'b0;
    sender_idles     = 1'b0;
    receiver_idles   = 1'b0;
    fail_count       = 0;
    clear_record();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    test_reset_settings();
    test_full_scale_pairs();
    test_zero_sizes();
    test_mid_record_changes();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    test_full_scale_bins();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    repeat (8) test_random_records(130, 1'b0);
    repeat (2) test_random_records(130, 1'b1);

    if (fail_count == 0) begin
      $display("** rebin_average_threshold_core: PASSED **");
    end else begin
      $display("** rebin_average_threshold_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
